// ----- hdl/bdpc_pkg.sv -----
// shared types and constants for the button debounce press classifier
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

	// time arithmetic width
	localparam int TIME_WIDTH_DEF = 32;

	// field widths
	localparam int NOW_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 8;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd0;

	// register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_DEBOUNCE_TIME   = 8'd0,
		REG_LONG_PRESS_TIME = 8'd1,
		REG_LATCHING_MODE   = 8'd2,
		REG_ACTIVE_HIGH     = 8'd3
	} cfg_reg_t;

	// input word
	typedef struct packed {
		logic                 pin_level;
		logic [NOW_WIDTH-1:0] now_time;
		logic                 ack_press;
		logic                 ack_long_press;
	} in_word_t;

	// result word
	typedef struct packed {
		logic is_pressed;
		logic press_taken;
		logic long_press_taken;
	} out_word_t;

	// configuration settings handed to the core
	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] long_press_time;
		logic        latching_mode;
		logic        active_high;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bdpc_cfg_regs.sv -----
// configuration register file of the press classifier
`timescale 1ns / 1ps
`default_nettype none

module bdpc_cfg_regs (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [bdpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output bdpc_pkg::cfg_t                             cfg
);

	bdpc_pkg::cfg_t cfg_q;

	// always able to take a word
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= bdpc_pkg::DEBOUNCE_RESET;
			cfg_q.long_press_time <= bdpc_pkg::LONG_PRESS_RESET;
			cfg_q.latching_mode   <= 1'b0;
			cfg_q.active_high     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdpc_pkg::REG_DEBOUNCE_TIME:   cfg_q.debounce_time <= cfg_data;
				bdpc_pkg::REG_LONG_PRESS_TIME: cfg_q.long_press_time <= cfg_data;
				bdpc_pkg::REG_LATCHING_MODE:   cfg_q.latching_mode <= cfg_data[0];
				bdpc_pkg::REG_ACTIVE_HIGH:     cfg_q.active_high <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bdpc_core.sv -----
// debounce state update, press classification and result register
`timescale 1ns / 1ps
`default_nettype none

module bdpc_core #(
	parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bdpc_pkg::cfg_t      cfg,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire bdpc_pkg::in_word_t  item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bdpc_pkg::out_word_t      out_data
);

	logic                  stable_q;
	logic                  last_q;
	logic                  short_q;
	logic                  long_q;
	logic [TIME_WIDTH-1:0] change_q;
	logic [TIME_WIDTH-1:0] press_q;
	logic                  out_valid_q;
	bdpc_pkg::out_word_t   out_q;

	logic                  take;
	logic                  sample;
	logic [TIME_WIDTH-1:0] now_t;
	logic                  last_n;
	logic [TIME_WIDTH-1:0] change_n;
	logic [TIME_WIDTH-1:0] settle_diff;
	logic [TIME_WIDTH-1:0] held;
	logic                  settle;
	logic                  long_hit;
	logic                  stable_n;
	logic [TIME_WIDTH-1:0] press_n;
	logic                  short_raise;
	logic                  long_raise;
	logic                  short_n;
	logic                  long_n;

	// result register frees up when empty or being taken
	assign item_ready = !out_valid_q || out_ready;
	assign take = item_valid && item_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// sample and settle timer
	always_comb begin
		now_t       = TIME_WIDTH'(item.now_time);
		sample      = (item.pin_level == cfg.active_high);
		last_n      = sample;
		change_n    = (sample != last_q) ? now_t : change_q;
		settle_diff = now_t - change_n;
		settle      = (last_n != stable_q) && (settle_diff >= TIME_WIDTH'(cfg.debounce_time));
		held        = now_t - press_q;
		long_hit    = (cfg.long_press_time != 16'd0) &&
			(held >= TIME_WIDTH'(cfg.long_press_time));
	end

	// stable state and event flags
	always_comb begin
		stable_n    = settle ? last_n : stable_q;
		press_n     = (settle && last_n) ? now_t : press_q;
		short_raise = 1'b0;
		long_raise  = 1'b0;
		if (settle) begin
			if (last_n) begin
				short_raise = cfg.latching_mode;
			end else if (!cfg.latching_mode) begin
				long_raise  = long_hit;
				short_raise = !long_hit;
			end
		end
		short_n = short_q || short_raise;
		long_n  = long_q || long_raise;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			last_q   <= 1'b0;
			short_q  <= 1'b0;
			long_q   <= 1'b0;
			change_q <= '0;
			press_q  <= '0;
		end else if (take) begin
			stable_q <= stable_n;
			last_q   <= last_n;
			short_q  <= short_n && !item.ack_press;
			long_q   <= long_n && !item.ack_long_press;
			change_q <= change_n;
			press_q  <= press_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.is_pressed       <= stable_n;
			out_q.press_taken      <= item.ack_press && short_n;
			out_q.long_press_taken <= item.ack_long_press && long_n;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/button_debounce_press_classifier.sv -----
// Button debounce and press classifier, top level.
// An accepted input word passes through the input register, then the result register.
// Throughput: one word per cycle while out_ready is high; a result stall backs up through both registers to in_ready.
// Reset: asynchronous, active low; button taken as released, flags clear, timers zero,
// debounce 20 ms, long press off, momentary, active low.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_press_classifier #(
	parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire bdpc_pkg::in_word_t                    in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output bdpc_pkg::out_word_t                        out_data,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [bdpc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	bdpc_pkg::cfg_t     cfg;
	logic               valid_s1;
	bdpc_pkg::in_word_t data_s1;
	logic               core_ready;

	// configuration registers
	bdpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	assign in_ready = !valid_s1 || core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// state update and result register
	bdpc_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item_ready (core_ready),
		.item       (data_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// self-checking testbench for the button debounce press classifier
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_PRINTED = 100;
	localparam int FIRST_UNMAPPED_INDEX = 4;
	localparam int PHASE_TICKS = 215;

	// idle schemes
	typedef enum int {
		IDLE_SEND_LIGHT,
		IDLE_SEND_HEAVY,
		IDLE_NONE
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bdpc_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bdpc_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [bdpc_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

	button_debounce_press_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies
	logic [15:0] cfg_debounce;
	logic [15:0] cfg_long_press;
	logic cfg_latching;
	logic cfg_active_high;

	// debouncer and classifier state
	logic btn_stable;
	logic btn_sample;
	logic short_flag;
	logic long_flag;
	logic [31:0] settle_start_ms;
	logic [31:0] hold_start_ms;

	bdpc_pkg::in_word_t tick_q[$];
	bdpc_pkg::out_word_t press_reports_q[$];
	int err_cnt = 0;
	int cycle_cnt = 0;
	idle_mode_t idle_mode = IDLE_SEND_LIGHT;
	int stall_req = 0;
	int stall_seen = 0;
	int stall_left = 0;
	logic in_taken = 1'b0;

	// stimulus generator state
	logic [31:0] gen_ms;
	bit gen_pressed;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// debounce and classify one tick, returns the expected result word
	function automatic bdpc_pkg::out_word_t classify_tick(bdpc_pkg::in_word_t w);
		bdpc_pkg::out_word_t r;
		logic sample;
		logic [31:0] held;
		sample = (w.pin_level == cfg_active_high);
		r = '0;
		if (sample != btn_sample) begin
			btn_sample = sample;
			settle_start_ms = w.now_time;
		end
		if (btn_sample != btn_stable
				&& (w.now_time - settle_start_ms) >= {16'b0, cfg_debounce}) begin
			btn_stable = btn_sample;
			if (btn_stable) begin
				hold_start_ms = w.now_time;
				if (cfg_latching)
					short_flag = 1'b1;
			end else if (!cfg_latching) begin
				held = w.now_time - hold_start_ms;
				if (cfg_long_press != 16'd0 && held >= {16'b0, cfg_long_press})
					long_flag = 1'b1;
				else
					short_flag = 1'b1;
			end
		end
		// flags raised this tick are reported this tick
		if (w.ack_press) begin
			r.press_taken = short_flag;
			short_flag = 1'b0;
		end
		if (w.ack_long_press) begin
			r.long_press_taken = long_flag;
			long_flag = 1'b0;
		end
		r.is_pressed = btn_stable;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic exp_bit, logic got_bit);
		if (err_cnt < MAX_PRINTED)
			$display("mismatch at cycle %0d: %s expected %b got %b", cycle_cnt, what, exp_bit,
				got_bit);
		err_cnt++;
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND_LIGHT: return $urandom_range(99, 0) < 15;
			IDLE_SEND_HEAVY: return $urandom_range(99, 0) < 51;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_idles();
		case (idle_mode)
			IDLE_SEND_LIGHT: return $urandom_range(99, 0) < 51;
			IDLE_SEND_HEAVY: return $urandom_range(99, 0) < 15;
			default: return 1'b0;
		endcase
	endfunction

	// input word driver
	always @(negedge clk) begin
		logic busy;
		busy = in_valid && !in_taken;
		if (!busy) begin
			if (tick_q.size() != 0 && !sender_idles()) begin
				in_data <= tick_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result ready, with one long hold-off on request
	always @(negedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			stall_left = LONG_STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && !receiver_idles();
		end
	end

	// accept monitor and result checker
	always @(posedge clk) begin
		bdpc_pkg::out_word_t exp_w;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				press_reports_q.push_back(classify_tick(in_data));
				in_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (press_reports_q.size() == 0) begin
					report_mismatch("unexpected word, valid", 1'b0, 1'b1);
				end else begin
					exp_w = press_reports_q.pop_front();
					if (out_data.is_pressed !== exp_w.is_pressed)
						report_mismatch("is_pressed", exp_w.is_pressed, out_data.is_pressed);
					if (out_data.press_taken !== exp_w.press_taken)
						report_mismatch("press_taken", exp_w.press_taken, out_data.press_taken);
					if (out_data.long_press_taken !== exp_w.long_press_taken)
						report_mismatch("long_press_taken", exp_w.long_press_taken,
							out_data.long_press_taken);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			bdpc_pkg::REG_DEBOUNCE_TIME: cfg_debounce = val;
			bdpc_pkg::REG_LONG_PRESS_TIME: cfg_long_press = val;
			bdpc_pkg::REG_LATCHING_MODE: cfg_latching = val[0];
			bdpc_pkg::REG_ACTIVE_HIGH: cfg_active_high = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one-bit registers get random upper bits, which the block drops
	task automatic set_config(logic [15:0] deb, logic [15:0] lp, bit latch, bit ah);
		write_reg(bdpc_pkg::REG_DEBOUNCE_TIME, deb);
		write_reg(bdpc_pkg::REG_LONG_PRESS_TIME, lp);
		write_reg(bdpc_pkg::REG_LATCHING_MODE, {15'($urandom()), latch});
		write_reg(bdpc_pkg::REG_ACTIVE_HIGH, {15'($urandom()), ah});
	endtask

	// wait until all words are through and the pipeline is empty
	task automatic wait_drained();
		while (tick_q.size() != 0 || press_reports_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_tick(bit pin, logic [31:0] now, bit a_s, bit a_l);
		bdpc_pkg::in_word_t w;
		w.pin_level = pin;
		w.now_time = now;
		w.ack_press = a_s;
		w.ack_long_press = a_l;
		tick_q.push_back(w);
	endfunction

	function automatic bit rnd_ack();
		return $urandom_range(3, 0) == 0;
	endfunction

	function automatic bit pin_for(bit pressed);
		return cfg_active_high ? pressed : !pressed;
	endfunction

	// press and release sequences with bounce, plus some noise ticks
	task automatic gen_ticks(int n);
		int made;
		int bounce;
		int hold;
		logic [31:0] step_max;
		made = 0;
		step_max = ({16'b0, cfg_debounce} >> 2) + 3;
		while (made < n) begin
			if ($urandom_range(99, 0) < 4) begin
				push_tick(1'($urandom_range(1, 0)), $urandom(), rnd_ack(), rnd_ack());
				made++;
			end else begin
				gen_pressed = !gen_pressed;
				bounce = $urandom_range(3, 0);
				for (int k = 0; k < bounce; k++) begin
					gen_ms += $urandom_range(1, 0);
					push_tick(pin_for((k % 2 == 0) ? gen_pressed : !gen_pressed), gen_ms,
						rnd_ack(), rnd_ack());
					made++;
				end
				// occasional big jump in time, wrapping as it falls
				if ($urandom_range(19, 0) == 0)
					gen_ms += $urandom();
				hold = $urandom_range(16, 1);
				for (int k = 0; k < hold; k++) begin
					gen_ms += $urandom_range(step_max, 0);
					push_tick(pin_for(gen_pressed), gen_ms, rnd_ack(), rnd_ack());
					made++;
				end
			end
		end
	endtask

	// main sequence
	initial begin
		cfg_debounce = bdpc_pkg::DEBOUNCE_RESET;
		cfg_long_press = bdpc_pkg::LONG_PRESS_RESET;
		cfg_latching = 1'b0;
		cfg_active_high = 1'b0;
		btn_stable = 1'b0;
		btn_sample = 1'b0;
		short_flag = 1'b0;
		long_flag = 1'b0;
		settle_start_ms = '0;
		hold_start_ms = '0;
		gen_ms = '0;
		gen_pressed = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed ticks on reset settings: active low, 20 ms debounce, momentary
		idle_mode = IDLE_SEND_LIGHT;
		push_tick(1'b1, 32'd0, 1'b0, 1'b0);
		push_tick(1'b0, 32'd5, 1'b0, 1'b0);
		push_tick(1'b0, 32'd24, 1'b0, 1'b0);
		push_tick(1'b0, 32'd25, 1'b1, 1'b1);
		push_tick(1'b1, 32'd30, 1'b0, 1'b0);
		push_tick(1'b0, 32'd35, 1'b0, 1'b0);
		push_tick(1'b1, 32'd40, 1'b0, 1'b0);
		push_tick(1'b1, 32'd60, 1'b1, 1'b0);
		push_tick(1'b1, 32'd61, 1'b1, 1'b1);
		// settle across the time wrap
		push_tick(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
		push_tick(1'b0, 32'h0000_0003, 1'b0, 1'b0);
		push_tick(1'b0, 32'h0000_0004, 1'b0, 1'b0);
		push_tick(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		push_tick(1'b1, 32'h0000_0013, 1'b0, 1'b0);
		// second release while the short flag is still pending
		push_tick(1'b0, 32'h0000_0014, 1'b0, 1'b0);
		push_tick(1'b0, 32'h0000_0028, 1'b0, 1'b0);
		push_tick(1'b1, 32'h0000_0029, 1'b0, 1'b0);
		push_tick(1'b1, 32'h0000_003D, 1'b0, 1'b0);
		push_tick(1'b1, 32'h0000_003E, 1'b1, 1'b1);
		wait_drained();

		// zero debounce, active high, short long-press limit
		set_config(16'd0, 16'd10, 1'b0, 1'b1);
		gen_ticks(PHASE_TICKS);
		wait_drained();

		// latching mode
		set_config(16'd5, 16'd30, 1'b1, 1'b0);
		gen_ticks(PHASE_TICKS);
		wait_drained();

		// largest long-press limit, time starting just before the wrap
		idle_mode = IDLE_SEND_HEAVY;
		set_config(16'd3, 16'hFFFF, 1'b0, 1'b0);
		gen_ms = 32'hFFFF_F000;
		gen_ticks(PHASE_TICKS);
		wait_drained();

		// largest debounce and long-press limits
		set_config(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		gen_ticks(PHASE_TICKS);
		wait_drained();

		// no idling, with a long result hold-off to fill the block
		idle_mode = IDLE_NONE;
		set_config(16'd1, 16'd1, 1'b1, 1'b1);
		gen_ticks(PHASE_TICKS);
		stall_req++;
		wait_drained();

		// unmapped register write, then momentary with reachable long presses
		write_reg(bdpc_pkg::CFG_INDEX_WIDTH'($urandom_range(255, FIRST_UNMAPPED_INDEX)),
			16'($urandom()));
		set_config(16'd10, 16'd40, 1'b0, 1'b0);
		gen_ticks(PHASE_TICKS);
		wait_drained();

		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/bdpc_pkg.sv
hdl/bdpc_cfg_regs.sv
hdl/bdpc_core.sv
hdl/button_debounce_press_classifier.sv
sim/tb.sv
